// ----- sv/three_point_local_frame_unit_defines.svh -----
// ----------------------------------------------------------------------------
// three_point_local_frame_unit_defines
// Assertion macros shared by the frame unit. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef THREE_POINT_LOCAL_FRAME_UNIT_DEFINES_SVH
`define THREE_POINT_LOCAL_FRAME_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset
`define TPLF_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define TPLF_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/tplf_pkg.sv -----
// ----------------------------------------------------------------------------
// tplf_pkg
// Word types and fixed arithmetic constants of the three point frame unit.
// ----------------------------------------------------------------------------
package tplf_pkg;

  localparam int COORD_WIDTH = 32;   // Q15.16 coordinates
  localparam int AXIS_WIDTH  = 32;   // Q1.30 axis components
  localparam int FRAC_BITS   = 30;

  // normalizer internals
  localparam int SCALE_BITS = 31;                 // scaled component width
  localparam int SUM_BITS   = 64;                 // sum of squares
  localparam int ROOT_BITS  = 32;
  localparam int REM_BITS   = ROOT_BITS + 3;
  localparam int NUM_BITS   = SCALE_BITS + FRAC_BITS + 1;
  localparam int QUO_BITS   = 32;
  localparam int SQ_PER     = 4;                  // root bits per stage
  localparam int SQ_STAGES  = ROOT_BITS / SQ_PER;
  localparam int DV_PER     = 4;                  // quotient bits per stage
  localparam int DV_STAGES  = QUO_BITS / DV_PER;
  localparam int NORM_STAGES = 5 + SQ_STAGES + 1 + DV_STAGES + 1;

  localparam logic [AXIS_WIDTH-1:0] ONE_Q30   = AXIS_WIDTH'(1) << FRAC_BITS;
  localparam logic [63:0]           ROUND_Q30 = 64'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] xpoint_x;
    logic signed [COORD_WIDTH-1:0] xpoint_y;
    logic signed [COORD_WIDTH-1:0] xpoint_z;
    logic signed [COORD_WIDTH-1:0] plane_point_x;
    logic signed [COORD_WIDTH-1:0] plane_point_y;
    logic signed [COORD_WIDTH-1:0] plane_point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [AXIS_WIDTH-1:0] xaxis_x;
    logic signed [AXIS_WIDTH-1:0] xaxis_y;
    logic signed [AXIS_WIDTH-1:0] xaxis_z;
    logic signed [AXIS_WIDTH-1:0] yaxis_x;
    logic signed [AXIS_WIDTH-1:0] yaxis_y;
    logic signed [AXIS_WIDTH-1:0] yaxis_z;
    logic signed [AXIS_WIDTH-1:0] zaxis_x;
    logic signed [AXIS_WIDTH-1:0] zaxis_y;
    logic signed [AXIS_WIDTH-1:0] zaxis_z;
    logic                         degenerate;
  } out_word_t;

endpackage

// ----- sv/three_point_local_frame_unit.sv -----
// ----------------------------------------------------------------------------
// three_point_local_frame_unit
// Orthonormal Q1.30 frame from an origin, an x point and an xy plane point.
// ----------------------------------------------------------------------------
// Usage:
//   pts / pts_valid / pts_ready carry one word of three Q15.16 points.
//   frame / frame_valid / frame_ready return one word per input: the x, y
//   and z unit axes in Q1.30 plus a degenerate flag (axes zero when set).
//   Throughput is one word per cycle while pts_ready is high; the depth
//   comes from the 8-stage square root and the 8-stage divider inside each
//   normalizer, four steps per stage.
//   All stages advance together. A two-word output buffer takes the last
//   stage's word, so the pipeline keeps running while one result waits;
//   pts_ready drops only once both buffer slots hold words.
//   Reset clears the valid bits and empties the buffer; no word is in flight after.
// ----------------------------------------------------------------------------
`include "three_point_local_frame_unit_defines.svh"

module three_point_local_frame_unit
  import tplf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pts_valid,
  output logic      pts_ready,
  input  in_word_t  pts,
  output logic      frame_valid,
  input  logic      frame_ready,
  output out_word_t frame
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW;
  localparam int SPW = PW + 1;
  localparam int CRW = PW + 2;
  localparam int ZW  = PW + 1;
  localparam int NPS = 6 + NORM_STAGES + 3;

  // operand pairs of the three cross products
  localparam int PA [6] = '{1, 2, 2, 0, 0, 1};
  localparam int PB [6] = '{2, 1, 0, 2, 1, 0};

  logic           en;
  logic [NPS-1:0] v;
  logic           push;
  logic           pop;
  logic [1:0]     cnt;

  assign en        = (cnt != 2'd2);
  assign pts_ready = en;
  assign push      = en && v[NPS-1];
  assign pop       = frame_valid && frame_ready;

  // valid bits move with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NPS-2:0], pts_valid};
    end
  end

  // stage 0: difference vectors
  logic signed [CW-1:0] o_c [3];
  logic signed [CW-1:0] p_c [3];
  logic signed [CW-1:0] q_c [3];
  logic signed [DW-1:0] d1_0 [3];
  logic signed [DW-1:0] d2_0 [3];

  assign o_c[0] = pts.origin_x;
  assign o_c[1] = pts.origin_y;
  assign o_c[2] = pts.origin_z;
  assign p_c[0] = pts.xpoint_x;
  assign p_c[1] = pts.xpoint_y;
  assign p_c[2] = pts.xpoint_z;
  assign q_c[0] = pts.plane_point_x;
  assign q_c[1] = pts.plane_point_y;
  assign q_c[2] = pts.plane_point_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_0[i] <= DW'(p_c[i]) - DW'(o_c[i]);
        d2_0[i] <= DW'(q_c[i]) - DW'(o_c[i]);
      end
    end
  end

  // stage 1: sign and magnitude
  logic [2:0][CW-1:0] m1a;
  logic [2:0][CW-1:0] m1b;
  logic [2:0]         s1a;
  logic [2:0]         s1b;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1a[i] <= CW'(d1_0[i][DW-1] ? -d1_0[i] : d1_0[i]);
        m1b[i] <= CW'(d2_0[i][DW-1] ? -d2_0[i] : d2_0[i]);
        s1a[i] <= d1_0[i][DW-1];
        s1b[i] <= d2_0[i][DW-1];
      end
    end
  end

  // stage 2: magnitude products
  logic [PW-1:0]      pm2 [6];
  logic [5:0]         ps2;
  logic [2:0][CW-1:0] mx2;
  logic [2:0]         gx2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        pm2[j] <= m1a[PA[j]] * m1b[PB[j]];
        ps2[j] <= s1a[PA[j]] ^ s1b[PB[j]];
      end
      mx2 <= m1a;
      gx2 <= s1a;
    end
  end

  // stage 3: signed products
  logic signed [SPW-1:0] sp3 [6];
  logic [2:0][CW-1:0]    mx3;
  logic [2:0]            gx3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        sp3[j] <= ps2[j] ? -$signed({1'b0, pm2[j]}) : $signed({1'b0, pm2[j]});
      end
      mx3 <= mx2;
      gx3 <= gx2;
    end
  end

  // stage 4: cross product
  logic signed [CRW-1:0] cr4 [3];
  logic [2:0][CW-1:0]    mx4;
  logic [2:0]            gx4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cr4[i] <= CRW'(sp3[2*i]) - CRW'(sp3[2*i+1]);
      end
      mx4 <= mx3;
      gx4 <= gx3;
    end
  end

  // stage 5: cross magnitude and zero test
  logic [2:0][ZW-1:0] cm5;
  logic [2:0]         cg5;
  logic               deg5;
  logic [2:0][CW-1:0] mx5;
  logic [2:0]         gx5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cm5[i] <= ZW'(cr4[i][CRW-1] ? -cr4[i] : cr4[i]);
        cg5[i] <= cr4[i][CRW-1];
      end
      deg5 <= (cr4[0] == '0) && (cr4[1] == '0) && (cr4[2] == '0);
      mx5  <= mx4;
      gx5  <= gx4;
    end
  end

  // normalizers for x and z axes
  logic [2:0][AXIS_WIDTH-1:0] xa_n;
  logic [2:0][AXIS_WIDTH-1:0] za_n;
  logic                       deg_d [NORM_STAGES];

  tplf_norm #(.W(CW)) u_norm_x (
    .clk  (clk),
    .en   (en),
    .mag  (mx5),
    .neg  (gx5),
    .axis (xa_n)
  );

  tplf_norm #(.W(ZW)) u_norm_z (
    .clk  (clk),
    .en   (en),
    .mag  (cm5),
    .neg  (cg5),
    .axis (za_n)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      deg_d[0] <= deg5;
      for (int k = 1; k < NORM_STAGES; k++) deg_d[k] <= deg_d[k-1];
    end
  end

  // y axis, stage Y1: products of z and x components
  logic signed [63:0]         yp [6];
  logic [2:0][AXIS_WIDTH-1:0] xa1, za1;
  logic                       dg1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        yp[j] <= $signed(za_n[PA[j]]) * $signed(xa_n[PB[j]]);
      end
      xa1 <= xa_n;
      za1 <= za_n;
      dg1 <= deg_d[NORM_STAGES-1];
    end
  end

  // stage Y2: differences
  logic signed [63:0]         yt [3];
  logic [2:0][AXIS_WIDTH-1:0] xa2, za2;
  logic                       dg2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) yt[i] <= yp[2*i] - yp[2*i+1];
      xa2 <= xa1;
      za2 <= za1;
      dg2 <= dg1;
    end
  end

  // stage Y3: magnitudes
  logic [63:0]                ym [3];
  logic [2:0]                 yg;
  logic [2:0][AXIS_WIDTH-1:0] xa3, za3;
  logic                       dg3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ym[i] <= yt[i][63] ? 64'(-yt[i]) : 64'(yt[i]);
        yg[i] <= yt[i][63];
      end
      xa3 <= xa2;
      za3 <= za2;
      dg3 <= dg2;
    end
  end

  // round half away, clamp, sign; assemble the result word
  logic [63:0]                rs [3];
  logic [33:0]                rr [3];
  logic [AXIS_WIDTH-1:0]      rc [3];
  logic [2:0][AXIS_WIDTH-1:0] ya_w;
  out_word_t                  wd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i]   = ym[i] + ROUND_Q30;
      rr[i]   = rs[i][63:FRAC_BITS];
      rc[i]   = (rr[i] > 34'(ONE_Q30)) ? ONE_Q30 : rr[i][AXIS_WIDTH-1:0];
      ya_w[i] = yg[i] ? -rc[i] : rc[i];
    end
    wd.xaxis_x    = dg3 ? '0 : $signed(xa3[0]);
    wd.xaxis_y    = dg3 ? '0 : $signed(xa3[1]);
    wd.xaxis_z    = dg3 ? '0 : $signed(xa3[2]);
    wd.yaxis_x    = dg3 ? '0 : $signed(ya_w[0]);
    wd.yaxis_y    = dg3 ? '0 : $signed(ya_w[1]);
    wd.yaxis_z    = dg3 ? '0 : $signed(ya_w[2]);
    wd.zaxis_x    = dg3 ? '0 : $signed(za3[0]);
    wd.zaxis_y    = dg3 ? '0 : $signed(za3[1]);
    wd.zaxis_z    = dg3 ? '0 : $signed(za3[2]);
    wd.degenerate = dg3;
  end

  // two-word output buffer: head is shown, spare catches one more word
  out_word_t head;
  out_word_t spare;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case (cnt)
        2'd0: begin
          if (push) begin
            head <= wd;
            cnt  <= 2'd1;
          end
        end
        2'd1: begin
          if (push && pop) begin
            head <= wd;
          end else if (push) begin
            spare <= wd;
            cnt   <= 2'd2;
          end else if (pop) begin
            cnt <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            head <= spare;
            cnt  <= 2'd1;
          end
        end
        default: cnt <= 2'd0;
      endcase
    end
  end

  assign frame_valid = (cnt != 2'd0);
  assign frame       = head;

  // checks
  `TPLF_IMPLY(a_deg_zero, frame_valid && frame.degenerate, (frame.xaxis_x == '0) && (frame.yaxis_y == '0) && (frame.zaxis_z == '0), "degenerate word with nonzero axes")
  `TPLF_IMPLY(a_unit_range, frame_valid && !frame.degenerate, ($signed(frame.zaxis_x) <= 32'sd1073741824) && ($signed(frame.zaxis_x) >= -32'sd1073741824), "axis component out of range")
  `TPLF_CHECK(a_no_overflow, !(push && (cnt == 2'd2)), "pipeline pushed into a full output buffer")

endmodule

// ----- sv/tplf_norm.sv -----
// ----------------------------------------------------------------------------
// tplf_norm
// Pipelined vector normalizer: common power-of-two scaling, sum of squares,
// digit-serial square root and per-component long division, Q1.30 out.
// ----------------------------------------------------------------------------
module tplf_norm
  import tplf_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [2:0][W-1:0]             mag,
  input  logic [2:0]                    neg,
  output logic [2:0][AXIS_WIDTH-1:0]    axis
);

  localparam int NC = (W + 7) / 8;
  localparam int LW = $clog2(W + 1);

  typedef struct packed {
    logic [2:0][SCALE_BITS-1:0] c;
    logic [2:0]                 g;
  } side_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    logic [SUM_BITS-1:0]  src;
  } sq_t;

  typedef struct packed {
    logic [QUO_BITS-1:0] rem;
    logic [QUO_BITS-1:0] q;
    logic [QUO_BITS-1:0] src;
  } dv_t;

  // a few restoring square root steps, two radicand bits each
  function automatic sq_t sq_iter(sq_t s);
    logic [REM_BITS-1:0] r;
    logic [REM_BITS-1:0] t;
    for (int j = 0; j < SQ_PER; j++) begin
      r = {s.rem[REM_BITS-3:0], s.src[SUM_BITS-1 -: 2]};
      t = REM_BITS'({s.root, 2'b01});
      if (r >= t) begin
        s.rem  = r - t;
        s.root = {s.root[ROOT_BITS-2:0], 1'b1};
      end else begin
        s.rem  = r;
        s.root = {s.root[ROOT_BITS-2:0], 1'b0};
      end
      s.src = s.src << 2;
    end
    return s;
  endfunction

  // a few restoring division steps, one quotient bit each
  function automatic dv_t dv_iter(dv_t s, logic [ROOT_BITS-1:0] n);
    logic [QUO_BITS:0] t;
    for (int j = 0; j < DV_PER; j++) begin
      t = {s.rem, s.src[QUO_BITS-1]};
      if (t >= {1'b0, n}) begin
        s.rem = QUO_BITS'(t - {1'b0, n});
        s.q   = {s.q[QUO_BITS-2:0], 1'b1};
      end else begin
        s.rem = t[QUO_BITS-1:0];
        s.q   = {s.q[QUO_BITS-2:0], 1'b0};
      end
      s.src = s.src << 1;
    end
    return s;
  endfunction

  // stage A: leading one per byte of the OR word
  logic [NC*8-1:0]        orw;
  logic [NC-1:0]          nz_c;
  logic [NC-1:0][2:0]     pos_c;
  logic [2:0][W-1:0]      m_a;
  logic [2:0]             g_a;
  logic [NC-1:0]          nz_a;
  logic [NC-1:0][2:0]     pos_a;

  always_comb begin
    orw = (NC*8)'(mag[0] | mag[1] | mag[2]);
    for (int c = 0; c < NC; c++) begin
      nz_c[c]  = |orw[c*8 +: 8];
      pos_c[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orw[c*8 + b]) pos_c[c] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_a   <= mag;
      g_a   <= neg;
      nz_a  <= nz_c;
      pos_a <= pos_c;
    end
  end

  // stage B: bit length of the largest component
  logic [LW-1:0]     len_c;
  logic [LW-1:0]     len_b;
  logic [2:0][W-1:0] m_b;
  logic [2:0]        g_b;

  always_comb begin
    len_c = '0;
    for (int c = 0; c < NC; c++) begin
      if (nz_a[c]) len_c = LW'(c*8 + 1) + LW'(pos_a[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_b <= len_c;
      m_b   <= m_a;
      g_b   <= g_a;
    end
  end

  // stage C: scale so the largest component has SCALE_BITS bits
  logic [2:0][W+SCALE_BITS-1:0] ext;
  side_t                        side_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {m_b[i], {SCALE_BITS{1'b0}}} >> len_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) side_c.c[i] <= ext[i][SCALE_BITS-1:0];
      side_c.g <= g_b;
    end
  end

  // stage D: squares
  logic [2:0][2*SCALE_BITS-1:0] sq_d;
  side_t                        side_d;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_d[i] <= side_c.c[i] * side_c.c[i];
      side_d <= side_c;
    end
  end

  // stage E: sum of squares
  logic [SUM_BITS-1:0] sum_e;
  side_t               side_e;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_e  <= SUM_BITS'(sq_d[0]) + SUM_BITS'(sq_d[1]) + SUM_BITS'(sq_d[2]);
      side_e <= side_d;
    end
  end

  // square root pipeline
  sq_t   sq_first;
  sq_t   sq_s   [SQ_STAGES];
  side_t side_s [SQ_STAGES];

  assign sq_first = '{rem: '0, root: '0, src: sum_e};

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s[0]   <= sq_iter(sq_first);
      side_s[0] <= side_e;
      for (int k = 1; k < SQ_STAGES; k++) begin
        sq_s[k]   <= sq_iter(sq_s[k-1]);
        side_s[k] <= side_s[k-1];
      end
    end
  end

  // stage F: rounded numerator c * 2^30 + n / 2
  logic [2:0][NUM_BITS-1:0] num_f;
  logic [ROOT_BITS-1:0]     n_f;
  logic [2:0]               g_f;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_f[i] <= NUM_BITS'({side_s[SQ_STAGES-1].c[i], {FRAC_BITS{1'b0}}})
                  + NUM_BITS'(sq_s[SQ_STAGES-1].root >> 1);
      end
      n_f <= sq_s[SQ_STAGES-1].root;
      g_f <= side_s[SQ_STAGES-1].g;
    end
  end

  // division pipeline, three lanes sharing the divisor
  dv_t  [2:0]           dv_first;
  dv_t  [2:0]           dv_s [DV_STAGES];
  logic [ROOT_BITS-1:0] n_dv [DV_STAGES];
  logic [2:0]           g_dv [DV_STAGES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_first[i].rem = QUO_BITS'(num_f[i][NUM_BITS-1:QUO_BITS]);
      dv_first[i].q   = '0;
      dv_first[i].src = num_f[i][QUO_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) dv_s[0][i] <= dv_iter(dv_first[i], n_f);
      n_dv[0] <= n_f;
      g_dv[0] <= g_f;
      for (int k = 1; k < DV_STAGES; k++) begin
        for (int i = 0; i < 3; i++) dv_s[k][i] <= dv_iter(dv_s[k-1][i], n_dv[k-1]);
        n_dv[k] <= n_dv[k-1];
        g_dv[k] <= g_dv[k-1];
      end
    end
  end

  // final stage: clamp to one and restore sign
  logic [2:0][AXIS_WIDTH-1:0] qc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_s[DV_STAGES-1][i].q > ONE_Q30) ? ONE_Q30
                                                 : dv_s[DV_STAGES-1][i].q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        axis[i] <= g_dv[DV_STAGES-1][i] ? -qc[i] : qc[i];
      end
    end
  end

endmodule
